@@ hdl/dcd_pkg.sv @@
// Shared types and constants for the directed cycle detector.
// No dependencies.
package dcd_pkg;
  localparam int MaxVertices = 256;
  localparam int MaxDegree   = 8;
  localparam int VW  = $clog2(MaxVertices);
  localparam int DW  = $clog2(MaxDegree);
  localparam int CW  = DW + 1;
  localparam int SW  = VW + 1;
  localparam int AW  = VW + DW;

  typedef enum logic [1:0] {
    REQ_ADD    = 2'd0,
    REQ_SEARCH = 2'd1,
    REQ_CLEAR  = 2'd2,
    REQ_NONE   = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    ST_ACCEPT  = 3'd0,
    ST_REJECT  = 3'd1,
    ST_CLEARED = 3'd2,
    ST_NOCYCLE = 3'd3,
    ST_CYCLE   = 3'd4,
    ST_BADNB   = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    COL_WHITE = 2'd0,
    COL_GRAY  = 2'd1,
    COL_BLACK = 2'd2,
    COL_RSVD  = 2'd3
  } color_e;
endpackage

@@ hdl/directed_cycle_detector.sv @@
// Directed cycle detector top level: control, memories and output stage.
// Depends on dcd_pkg.
//
// Usage: one input channel (req_type_i, src_vertex_i, dst_vertex_i) with
// in_valid_i/in_ready_o, one output channel status_o with out_valid_o /
// out_ready_i. One status beat per input beat, in order.
// The user must write vertex_count through cfg_we_i/cfg_wdata_i only while
// idle; the block itself does not enforce it. Add edge: degree read, then
// write. Clear: one degree entry per cycle. Search: a colour mark clear
// sweep, then a colour check per root candidate, a top, degree, neighbour,
// colour and pop step per edge slot followed and all but the colour step
// per vertex pop. Reset clears control state and runs a sweep clearing the
// degree memory; no beat is accepted until it ends. A stalled receiver
// holds the result in the output register; the block takes the next beat
// only once that register is free.
module directed_cycle_detector import dcd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [8:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] req_type_i,
  input  logic [7:0] src_vertex_i,
  input  logic [7:0] dst_vertex_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] status_o
);
  typedef enum logic [11:0] {
    S_SWEEP = 12'b000000000001,
    S_IDLE  = 12'b000000000010,
    S_ADD   = 12'b000000000100,
    S_CLRC  = 12'b000000001000,
    S_ROOT  = 12'b000000010000,
    S_RCHK  = 12'b000000100000,
    S_TOP   = 12'b000001000000,
    S_DEG   = 12'b000010000000,
    S_NB    = 12'b000100000000,
    S_COL   = 12'b001000000000,
    S_POP   = 12'b010000000000,
    S_DONE  = 12'b100000000000
  } state_e;

  state_e state_q, state_d;
  logic [8:0] vcount_q;
  logic [SW-1:0] cnt_q, cnt_d;
  logic [SW-1:0] sp_q, sp_d;
  logic [VW-1:0] v_q, v_d, nb_q, nb_d;
  logic [CW-1:0] c_q, c_d;
  logic [2:0] res_q, res_d;
  logic out_valid_q;
  logic start_out;
  logic [1:0] req_q;
  logic [VW-1:0] src_q, dst_q;
  logic [8:0] n_eff;

  // memories
  logic [VW-1:0] adj_mem [1 << AW];
  logic [CW-1:0] deg_mem [MaxVertices];
  logic [1:0]    col_mem [MaxVertices];
  logic [VW-1:0] stv_mem [MaxVertices];
  logic [CW-1:0] stc_mem [MaxVertices];

  logic adj_we, deg_we, col_we, st_we;
  logic [AW-1:0] adj_addr;
  logic [VW-1:0] adj_wd, deg_addr, col_addr, st_addr;
  logic [CW-1:0] deg_wd, stc_wd;
  logic [1:0] col_wd;
  logic [VW-1:0] stv_wd;
  logic [VW-1:0] adj_rd, stv_rd;
  logic [CW-1:0] deg_rd, stc_rd;
  logic [1:0] col_rd;

  always_ff @(posedge clk_i) begin
    if (adj_we) adj_mem[adj_addr] <= adj_wd;
    adj_rd <= adj_mem[adj_addr];
    if (deg_we) deg_mem[deg_addr] <= deg_wd;
    deg_rd <= deg_mem[deg_addr];
    if (col_we) col_mem[col_addr] <= col_wd;
    col_rd <= col_mem[col_addr];
    if (st_we) begin
      stv_mem[st_addr] <= stv_wd;
      stc_mem[st_addr] <= stc_wd;
    end
    stv_rd <= stv_mem[st_addr];
    stc_rd <= stc_mem[st_addr];
  end

  assign n_eff = (vcount_q > 9'(MaxVertices)) ? 9'(MaxVertices) : vcount_q;
  assign in_ready_o = (state_q == S_IDLE) && !out_valid_q;
  assign out_valid_o = out_valid_q;
  assign status_o = res_q;

  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q; sp_d = sp_q; v_d = v_q; c_d = c_q; nb_d = nb_q;
    res_d = res_q; start_out = 1'b0;
    adj_we = 1'b0; deg_we = 1'b0; col_we = 1'b0; st_we = 1'b0;
    adj_addr = {v_q, c_q[DW-1:0]}; adj_wd = dst_q;
    deg_addr = v_q; deg_wd = '0;
    col_addr = nb_q; col_wd = COL_WHITE;
    st_addr = VW'(sp_q - 1'b1); stv_wd = nb_q; stc_wd = '0;
    case (state_q)
      S_SWEEP: begin
        deg_we = 1'b1; deg_addr = cnt_q[VW-1:0];
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == SW'(MaxVertices - 1)) begin
          // the sweep after reset answers nothing
          if (req_q == REQ_CLEAR) begin
            res_d = ST_CLEARED; state_d = S_DONE;
          end else state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          cnt_d = '0;
          case (req_e'(req_type_i))
            REQ_ADD: begin
              deg_addr = src_vertex_i;
              if ({1'b0, src_vertex_i} < n_eff) state_d = S_ADD;
              else begin res_d = ST_REJECT; start_out = 1'b1; end
            end
            REQ_SEARCH: state_d = S_CLRC;
            REQ_CLEAR: state_d = S_SWEEP;
            default: begin res_d = ST_REJECT; start_out = 1'b1; end
          endcase
        end
      end
      S_ADD: begin
        deg_addr = src_q;
        if (deg_rd >= CW'(MaxDegree)) res_d = ST_REJECT;
        else begin
          res_d = ST_ACCEPT;
          deg_we = 1'b1; deg_wd = deg_rd + 1'b1;
          adj_we = 1'b1; adj_addr = {src_q, deg_rd[DW-1:0]};
        end
        start_out = 1'b1; state_d = S_IDLE;
      end
      S_CLRC: begin
        col_we = 1'b1; col_addr = cnt_q[VW-1:0];
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == SW'(MaxVertices - 1)) begin
          cnt_d = '0; state_d = S_ROOT;
        end
      end
      S_ROOT: begin
        // cnt_q is the root candidate
        if (cnt_q >= n_eff) begin
          res_d = ST_NOCYCLE; state_d = S_DONE;
        end else begin
          col_addr = cnt_q[VW-1:0]; state_d = S_RCHK;
        end
      end
      S_RCHK: begin
        if (col_rd == COL_WHITE) begin
          col_we = 1'b1; col_addr = cnt_q[VW-1:0]; col_wd = COL_GRAY;
          st_we = 1'b1; st_addr = '0; stv_wd = cnt_q[VW-1:0];
          sp_d = SW'(1); state_d = S_TOP;
        end else begin
          cnt_d = cnt_q + 1'b1; state_d = S_ROOT;
        end
      end
      S_TOP: begin
        if (sp_q == '0) begin
          cnt_d = cnt_q + 1'b1; state_d = S_ROOT;
        end else state_d = S_DEG;
      end
      S_DEG: begin
        v_d = stv_rd; c_d = stc_rd;
        deg_addr = stv_rd;
        adj_addr = {stv_rd, stc_rd[DW-1:0]};
        state_d = S_NB;
      end
      S_NB: begin
        if (c_q < deg_rd) begin
          st_we = 1'b1; stv_wd = v_q; stc_wd = c_q + 1'b1;
          nb_d = adj_rd; col_addr = adj_rd;
          if ({1'b0, adj_rd} >= n_eff) begin
            res_d = ST_BADNB; state_d = S_DONE;
          end else state_d = S_COL;
        end else begin
          col_we = 1'b1; col_addr = v_q; col_wd = COL_BLACK;
          sp_d = sp_q - 1'b1; state_d = S_POP;
        end
      end
      S_COL: begin
        if (col_rd == COL_GRAY) begin
          res_d = ST_CYCLE; state_d = S_DONE;
        end else if (col_rd == COL_WHITE && sp_q < SW'(MaxVertices)) begin
          col_we = 1'b1; col_wd = COL_GRAY;
          st_we = 1'b1; st_addr = sp_q[VW-1:0]; stv_wd = nb_q; stc_wd = '0;
          sp_d = sp_q + 1'b1; state_d = S_POP;
        end else state_d = S_POP;
      end
      S_POP: begin
        // stack read of new top issued here via st_addr
        state_d = S_TOP;
      end
      S_DONE: begin
        start_out = 1'b1; state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_SWEEP;
      vcount_q <= 9'd8;
      cnt_q <= '0; sp_q <= '0;
      out_valid_q <= 1'b0;
      req_q <= REQ_NONE;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d; sp_q <= sp_d;
      if (cfg_we_i) vcount_q <= cfg_wdata_i;
      if (start_out) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      if (in_valid_i && in_ready_o) req_q <= req_type_i;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q <= v_d; c_q <= c_d; nb_q <= nb_d; res_q <= res_d;
    if (in_valid_i && in_ready_o) begin
      src_q <= src_vertex_i; dst_q <= dst_vertex_i;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !in_ready_o) else $error("accept while busy");
  a_sp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= SW'(MaxVertices)) else $error("stack overflow");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(status_o)))
    else $error("result dropped");
`endif
endmodule

@@ bench/directed_cycle_detector_tb.sv @@
// Testbench for directed_cycle_detector: directed and random graph loads,
// clears and cycle searches, checked against an in-bench search model.
// Depends on dcd_pkg and the directed_cycle_detector RTL.
`timescale 1ns / 100ps

module directed_cycle_detector_tb import dcd_pkg::*; ();

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [8:0] cfg_wdata_i;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [1:0] req_type_i;
  logic [7:0] src_vertex_i;
  logic [7:0] dst_vertex_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic [2:0] status_o;

  directed_cycle_detector dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .req_type_i  (req_type_i),
    .src_vertex_i(src_vertex_i),
    .dst_vertex_i(dst_vertex_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_o    (status_o)
  );

  localparam int CycleLimit = 4000000;

  // graph shadow
  logic [8:0] vcount;
  logic [7:0] adj [MaxVertices*MaxDegree];
  int unsigned degree [MaxVertices];
  color_e     mark [MaxVertices];
  logic [7:0] stk_v [MaxVertices];
  int unsigned stk_c [MaxVertices];

  status_e    status_q[$];
  int         mismatches;
  int         idle_pct;
  int         stall_pct;
  bit         hold_off;
  int         hold_cycles;
  longint     cycles;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned live_vertices();
    return (vcount < MaxVertices) ? vcount : MaxVertices;
  endfunction

  function automatic status_e search_graph();
    int unsigned n;
    int unsigned depth;
    int unsigned v;
    int unsigned c;
    int unsigned nb;
    n = live_vertices();
    for (int i = 0; i < MaxVertices; i++) mark[i] = COL_WHITE;
    for (int unsigned root = 0; root < n; root++) begin
      if (mark[root] != COL_WHITE) continue;
      mark[root] = COL_GRAY;
      stk_v[0] = root[7:0];
      stk_c[0] = 0;
      depth = 1;
      while (depth > 0) begin
        v = stk_v[depth-1];
        c = stk_c[depth-1];
        if (c < degree[v]) begin
          nb = adj[v*MaxDegree + c];
          stk_c[depth-1] = c + 1;
          if (nb >= n) return ST_BADNB;
          if (mark[nb] == COL_GRAY) return ST_CYCLE;
          if (mark[nb] == COL_WHITE && depth < MaxVertices) begin
            mark[nb] = COL_GRAY;
            stk_v[depth] = nb[7:0];
            stk_c[depth] = 0;
            depth++;
          end
        end else begin
          mark[v] = COL_BLACK;
          depth--;
        end
      end
    end
    return ST_NOCYCLE;
  endfunction

  function automatic status_e predict_status(req_e req, logic [7:0] src, logic [7:0] dst);
    case (req)
      REQ_ADD: begin
        if (src >= live_vertices() || degree[src] >= MaxDegree) return ST_REJECT;
        adj[src*MaxDegree + degree[src]] = dst;
        degree[src]++;
        return ST_ACCEPT;
      end
      REQ_SEARCH: return search_graph();
      REQ_CLEAR: begin
        for (int i = 0; i < MaxVertices; i++) degree[i] = 0;
        return ST_CLEARED;
      end
      default: return ST_REJECT;
    endcase
  endfunction

  task automatic send_beat(req_e req, logic [7:0] src, logic [7:0] dst);
    if ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    in_valid_i   <= 1'b1;
    req_type_i   <= req;
    src_vertex_i <= src;
    dst_vertex_i <= dst;
    status_q.push_back(predict_status(req, src, dst));
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (status_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_vcount(logic [8:0] value);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    vcount = value;
  endtask

  // receiver and checker
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (status_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected status beat %0d", status_o);
        end else begin
          if (status_o !== status_q[0]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("status mismatch: expected %0d actual %0d", status_q[0], status_o);
          end
          void'(status_q.pop_front());
        end
      end
      out_ready_i <= !hold_off && ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles--;
      hold_off <= (hold_cycles > 1);
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic test_directed();
    send_beat(REQ_SEARCH, 0, 0);
    send_beat(REQ_ADD, 0, 1);
    send_beat(REQ_ADD, 1, 2);
    send_beat(REQ_SEARCH, 0, 0);
    send_beat(REQ_ADD, 2, 0);
    send_beat(REQ_SEARCH, 0, 0);
    send_beat(REQ_ADD, 8'hff, 0);
    send_beat(REQ_ADD, 8, 0);
    send_beat(REQ_NONE, 8'hff, 8'hff);
    send_beat(REQ_CLEAR, 0, 0);
    send_beat(REQ_ADD, 3, 8'hff);
    send_beat(REQ_SEARCH, 0, 0);
    send_beat(REQ_CLEAR, 0, 0);
    for (int i = 0; i < 9; i++) send_beat(REQ_ADD, 7, 8'(i % 7));
    send_beat(REQ_SEARCH, 0, 0);
    send_beat(REQ_CLEAR, 0, 0);
  endtask

  task automatic test_extremes();
    write_vcount(9'd0);
    send_beat(REQ_ADD, 0, 0);
    send_beat(REQ_SEARCH, 0, 0);
    write_vcount(9'h1ff);
    send_beat(REQ_ADD, 8'hff, 8'hfe);
    send_beat(REQ_ADD, 8'hfe, 8'hff);
    send_beat(REQ_SEARCH, 0, 0);
    write_vcount(9'd256);
    send_beat(REQ_SEARCH, 0, 0);
    write_vcount(9'd1);
    send_beat(REQ_ADD, 0, 0);
    send_beat(REQ_SEARCH, 0, 0);
    send_beat(REQ_CLEAR, 0, 0);
  endtask

  task automatic random_graphs(int beats, int vmax);
    int   n;
    int   r;
    req_e req;
    n = 1;
    for (int i = 0; i < beats; i++) begin
      if (i % 40 == 0) begin
        n = $urandom_range(vmax, 1);
        write_vcount(9'(n));
        send_beat(REQ_CLEAR, 8'($urandom), 8'($urandom));
      end
      r = $urandom_range(99);
      req = (r < 75) ? REQ_ADD : (r < 90) ? REQ_SEARCH : (r < 96) ? REQ_CLEAR : REQ_NONE;
      if (req == REQ_ADD && $urandom_range(9) != 0)
        send_beat(req, 8'($urandom_range(n - 1)), 8'($urandom_range(n + (n / 8))));
      else
        send_beat(req, 8'($urandom), 8'($urandom));
    end
  endtask

  task automatic test_random();
    idle_pct = 0;  stall_pct = 0;  random_graphs(250, 24);
    idle_pct = 82; stall_pct = 0;  random_graphs(200, 24);
    idle_pct = 0;  stall_pct = 82; random_graphs(200, 24);
    idle_pct = 38; stall_pct = 38; random_graphs(250, 24);
    idle_pct = 0;  stall_pct = 0;  random_graphs(80, 256);
  endtask

  task automatic test_backpressure();
    hold_cycles = 400;
    for (int i = 0; i < 12; i++) send_beat(REQ_ADD, 8'(i % 4), 8'($urandom_range(3)));
    send_beat(REQ_SEARCH, 0, 0);
  endtask

  initial begin
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_wdata_i  = '0;
    in_valid_i   = 1'b0;
    req_type_i   = REQ_ADD;
    src_vertex_i = '0;
    dst_vertex_i = '0;
    out_ready_i  = 1'b0;
    hold_cycles  = 0;
    mismatches   = 0;
    cycles       = 0;
    idle_pct     = 0;
    stall_pct    = 0;
    vcount       = 9'd8;
    for (int i = 0; i < MaxVertices; i++) degree[i] = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_extremes();
    write_vcount(9'd4);
    test_backpressure();
    test_random();

    drain();
    repeat (2000) @(posedge clk_i);
    if (mismatches == 0 && status_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
hdl/dcd_pkg.sv
hdl/directed_cycle_detector.sv
bench/directed_cycle_detector_tb.sv
